// ===== rtl/rc_receiver_hop_controller_top_macros.svh =====
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef RC_RECEIVER_HOP_CONTROLLER_TOP_MACROS_SVH
`define RC_RECEIVER_HOP_CONTROLLER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define RCHC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define RCHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rchc_pkg.sv =====
package rchc_pkg;

    localparam int unsigned MAX_SKIP_VAL = 9;
    localparam int unsigned SKIP_W = 4;
    localparam logic [SKIP_W-1:0] MAX_SKIP = SKIP_W'(MAX_SKIP_VAL);

    localparam logic [7:0] DATA_HEADER = 8'h55;
    localparam logic [3:0] OFFSET_CAP = 4'd9;
    localparam logic [16:0] TIMER_MAX = 17'h1FFFF;

    localparam logic [31:0] TX_ID_RESET = 32'd0;
    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd28000;
    localparam logic [15:0] HOP_PERIOD_RESET = 16'd1450;
    localparam logic [15:0] READ_DELAY_RESET = 16'd2600;

    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TX_ID        = 2'd0,
        REG_IDLE_TIMEOUT = 2'd1,
        REG_HOP_PERIOD   = 2'd2,
        REG_READ_DELAY   = 2'd3
    } reg_addr_t;

    typedef enum logic [1:0] {
        CMD_POLL    = 2'd0,
        CMD_ERROR   = 2'd1,
        CMD_PACKET  = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_CRC      = 3'd2,
        ST_FORMAT   = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_ACCEPT   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_SKIP = 2'd2,
        S_OUT  = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] elapsed_us;
        logic [7:0]  header_byte;
        logic [31:0] packet_id;
        logic [47:0] msb_bytes;
        logic [15:0] loop_time_us;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]        radio_channel;
        logic [2:0]        status;
        logic [SKIP_W-1:0] skipped;
    } out_beat_t;

    typedef struct packed {
        logic              done;
        logic [SKIP_W-1:0] count;
    } skip_stat_t;

    localparam logic [7:0] HOP_TABLE [8][16] = '{
        '{8'h0a, 8'h5a, 8'h14, 8'h64, 8'h1e, 8'h6e, 8'h28, 8'h78,
          8'h32, 8'h82, 8'h3c, 8'h8c, 8'h46, 8'h96, 8'h50, 8'ha0},
        '{8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64, 8'h46, 8'h96,
          8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h28, 8'h78, 8'h32, 8'h82},
        '{8'h28, 8'h78, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64,
          8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96},
        '{8'h50, 8'ha0, 8'h28, 8'h78, 8'h0a, 8'h5a, 8'h1e, 8'h6e,
          8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96, 8'h14, 8'h64},
        '{8'h50, 8'ha0, 8'h46, 8'h96, 8'h3c, 8'h8c, 8'h28, 8'h78,
          8'h0a, 8'h5a, 8'h32, 8'h82, 8'h1e, 8'h6e, 8'h14, 8'h64},
        '{8'h46, 8'h96, 8'h3c, 8'h8c, 8'h50, 8'ha0, 8'h28, 8'h78,
          8'h0a, 8'h5a, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64},
        '{8'h46, 8'h96, 8'h0a, 8'h5a, 8'h3c, 8'h8c, 8'h14, 8'h64,
          8'h50, 8'ha0, 8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82},
        '{8'h46, 8'h96, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h3c, 8'h8c,
          8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64}
    };

    function automatic logic [7:0] channel_of(input logic [31:0] id, input logic [3:0] col);
        logic [3:0] off;
        begin
            off = (id[7:4] > OFFSET_CAP) ? OFFSET_CAP : id[7:4];
            channel_of = HOP_TABLE[id[3:1]][col] - {4'd0, off} - 8'd1;
        end
    endfunction

    function automatic logic [3:0] hop_step(input logic [31:0] id);
        begin
            hop_step = id[0] ? 4'hF : 4'h1;
        end
    endfunction

endpackage

// ===== rtl/rchc_skip_unit.sv =====
module rchc_skip_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [16:0]         rem_init,
    input  logic [15:0]         period,
    output rchc_pkg::skip_stat_t stat
);

    logic                        busy_reg, busy_next;
    logic [16:0]                 rem_reg, rem_next;
    logic [rchc_pkg::SKIP_W-1:0] cnt_reg, cnt_next;
    logic                        stop;

    // one compare and one subtract per cycle while busy
    assign stop = (cnt_reg == rchc_pkg::MAX_SKIP) || (rem_reg < {1'b0, period});

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = rem_init;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (stop)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = rem_reg - {1'b0, period};
                cnt_next = cnt_reg + rchc_pkg::SKIP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done  = busy_reg && stop;
    assign stat.count = cnt_reg;

endmodule

// ===== rtl/rc_receiver_hop_controller_top.sv =====
// Receiver hop controller. Each event beat is taken when in_valid is high and in_stall low,
// and gives exactly one result beat. An event passes accept, evaluate and result load; an
// accepted packet also goes through the subtract-and-compare unit, which counts whole hop
// periods, up to MAX_SKIP of 9. in_stall stays high from acceptance until the result is
// loaded into the output register, which holds it while out_stall is high. The user must write
// registers over the APB port only while no event is in flight; nothing here enforces it.
`include "rc_receiver_hop_controller_top_macros.svh"

module rc_receiver_hop_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rchc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rchc_pkg::in_beat_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rchc_pkg::out_beat_t            out_data
);

    logic [31:0] tx_id_reg;
    logic [15:0] idle_timeout_reg;
    logic [15:0] hop_period_reg;
    logic [15:0] read_delay_reg;

    rchc_pkg::state_t    state_reg, state_next;
    rchc_pkg::in_beat_t  in_reg;
    rchc_pkg::out_beat_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          col_reg, col_next;
    logic [16:0]         idle_timer_reg, idle_timer_next;
    logic [2:0]          status_reg, status_next;
    logic [rchc_pkg::SKIP_W-1:0] skipped_reg, skipped_next;

    logic        in_accept;
    logic        cfg_write;
    logic [17:0] timer_sum;
    logic [16:0] timer_sat;
    logic        format_ok;
    logic        skip_start;
    logic [16:0] rem_init;
    logic [3:0]  step;
    rchc_pkg::skip_stat_t skip_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg        <= rchc_pkg::TX_ID_RESET;
            idle_timeout_reg <= rchc_pkg::IDLE_TIMEOUT_RESET;
            hop_period_reg   <= rchc_pkg::HOP_PERIOD_RESET;
            read_delay_reg   <= rchc_pkg::READ_DELAY_RESET;
        end
        else if (cfg_write)
        begin
            case (rchc_pkg::reg_addr_t'(paddr[3:2]))
                rchc_pkg::REG_TX_ID:        tx_id_reg        <= pwdata;
                rchc_pkg::REG_IDLE_TIMEOUT: idle_timeout_reg <= pwdata[15:0];
                rchc_pkg::REG_HOP_PERIOD:   hop_period_reg   <= pwdata[15:0];
                rchc_pkg::REG_READ_DELAY:   read_delay_reg   <= pwdata[15:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (rchc_pkg::reg_addr_t'(paddr[3:2]))
            rchc_pkg::REG_TX_ID:        prdata = tx_id_reg;
            rchc_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, idle_timeout_reg};
            rchc_pkg::REG_HOP_PERIOD:   prdata = {16'd0, hop_period_reg};
            rchc_pkg::REG_READ_DELAY:   prdata = {16'd0, read_delay_reg};
            default:                    prdata = '0;
        endcase
    end

    assign in_stall  = (state_reg != rchc_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign timer_sum = {1'b0, idle_timer_reg} + {2'b00, in_reg.elapsed_us};
    assign timer_sat = timer_sum[17] ? rchc_pkg::TIMER_MAX : timer_sum[16:0];
    assign step      = rchc_pkg::hop_step(tx_id_reg);
    assign rem_init  = {1'b0, in_reg.loop_time_us} + {1'b0, read_delay_reg};

    // header must be DATA_HEADER and every channel msb byte must have a clear upper nibble
    always_comb
    begin
        format_ok = (in_reg.header_byte == rchc_pkg::DATA_HEADER);
        for (int i = 0; i < 6; i++)
        begin
            if (in_reg.msb_bytes[8*i+4 +: 4] != 4'd0)
            begin
                format_ok = 1'b0;
            end
        end
    end

    rchc_skip_unit u_skip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (skip_start),
        .rem_init (rem_init),
        .period   (hop_period_reg),
        .stat     (skip_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        idle_timer_next = idle_timer_reg;
        status_next     = status_reg;
        skipped_next    = skipped_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        skip_start      = 1'b0;
        case (state_reg)
            rchc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = rchc_pkg::S_EVAL;
                end
            end
            rchc_pkg::S_EVAL:
            begin
                skipped_next    = '0;
                idle_timer_next = timer_sat;
                state_next      = rchc_pkg::S_OUT;
                case (rchc_pkg::cmd_t'(in_reg.cmd))
                    rchc_pkg::CMD_POLL:
                    begin
                        status_next = rchc_pkg::ST_IDLE;
                        if (timer_sat > {1'b0, idle_timeout_reg})
                        begin
                            col_next        = col_reg + step;
                            idle_timer_next = '0;
                            status_next     = rchc_pkg::ST_TIMEOUT;
                        end
                    end
                    rchc_pkg::CMD_ERROR:
                    begin
                        status_next = rchc_pkg::ST_CRC;
                    end
                    rchc_pkg::CMD_PACKET:
                    begin
                        if (!format_ok)
                        begin
                            status_next = rchc_pkg::ST_FORMAT;
                        end
                        else if (in_reg.packet_id != tx_id_reg)
                        begin
                            status_next = rchc_pkg::ST_MISMATCH;
                        end
                        else
                        begin
                            status_next     = rchc_pkg::ST_ACCEPT;
                            idle_timer_next = '0;
                            skip_start      = 1'b1;
                            state_next      = rchc_pkg::S_SKIP;
                        end
                    end
                    rchc_pkg::CMD_RESTART:
                    begin
                        col_next        = step;
                        idle_timer_next = '0;
                        status_next     = rchc_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        status_next = rchc_pkg::ST_IDLE;
                    end
                endcase
            end
            rchc_pkg::S_SKIP:
            begin
                if (skip_stat.done)
                begin
                    col_next     = col_reg + 4'(skip_stat.count) + step;
                    skipped_next = skip_stat.count;
                    state_next   = rchc_pkg::S_OUT;
                end
            end
            rchc_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.radio_channel = rchc_pkg::channel_of(tx_id_reg, col_reg);
                    out_next.status        = status_reg;
                    out_next.skipped       = skipped_reg;
                    out_valid_next         = 1'b1;
                    state_next             = rchc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rchc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rchc_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            col_reg        <= '0;
            idle_timer_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            col_reg        <= col_next;
            idle_timer_reg <= idle_timer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= in_data;
        end
        out_reg     <= out_next;
        status_reg  <= status_next;
        skipped_reg <= skipped_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `RCHC_ASSERT_SAME(a_skip_only_accept, out_valid_reg && (out_reg.skipped != '0), out_reg.status == rchc_pkg::ST_ACCEPT, "skip count on a beat that is not an accepted packet")
    `RCHC_ASSERT_SAME(a_skip_cap, out_valid_reg, out_reg.skipped <= rchc_pkg::MAX_SKIP, "skip count above cap")
    `RCHC_ASSERT_NEXT(a_accept_eval, in_valid && !in_stall, state_reg == rchc_pkg::S_EVAL, "accepted beat not evaluated next")
    `RCHC_ASSERT_NEXT(a_skip_timer_clear, (state_reg == rchc_pkg::S_SKIP) && skip_stat.done, idle_timer_reg == '0, "idle timer not cleared after accepted packet")

endmodule

// ===== tb/sv/hop_checker.sv =====
module hop_checker
    import rchc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_beat_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_beat_t          out_data,
    output int                 fail_count,
    output int                 pending,
    output int                 checked,
    output int                 accepted_pkts,
    output int                 timeout_hops
);

    localparam logic [7:0]  SYNC_HEADER = 8'h55;
    localparam int          SKIP_CAP    = 9;
    localparam logic [3:0]  OFFSET_MAX  = 4'd9;
    localparam logic [16:0] SILENCE_SAT = 17'h1FFFF;
    localparam int          PRINT_CAP   = 100;

    localparam logic [7:0] CHAN_TABLE [8][16] = '{
        '{8'h0a, 8'h5a, 8'h14, 8'h64, 8'h1e, 8'h6e, 8'h28, 8'h78,
          8'h32, 8'h82, 8'h3c, 8'h8c, 8'h46, 8'h96, 8'h50, 8'ha0},
        '{8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64, 8'h46, 8'h96,
          8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h28, 8'h78, 8'h32, 8'h82},
        '{8'h28, 8'h78, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h14, 8'h64,
          8'h1e, 8'h6e, 8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96},
        '{8'h50, 8'ha0, 8'h28, 8'h78, 8'h0a, 8'h5a, 8'h1e, 8'h6e,
          8'h3c, 8'h8c, 8'h32, 8'h82, 8'h46, 8'h96, 8'h14, 8'h64},
        '{8'h50, 8'ha0, 8'h46, 8'h96, 8'h3c, 8'h8c, 8'h28, 8'h78,
          8'h0a, 8'h5a, 8'h32, 8'h82, 8'h1e, 8'h6e, 8'h14, 8'h64},
        '{8'h46, 8'h96, 8'h3c, 8'h8c, 8'h50, 8'ha0, 8'h28, 8'h78,
          8'h0a, 8'h5a, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64},
        '{8'h46, 8'h96, 8'h0a, 8'h5a, 8'h3c, 8'h8c, 8'h14, 8'h64,
          8'h50, 8'ha0, 8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82},
        '{8'h46, 8'h96, 8'h0a, 8'h5a, 8'h50, 8'ha0, 8'h3c, 8'h8c,
          8'h28, 8'h78, 8'h1e, 8'h6e, 8'h32, 8'h82, 8'h14, 8'h64}
    };

    logic [31:0] bound_id;
    logic [15:0] silence_limit;
    logic [15:0] dwell_us;
    logic [15:0] proc_delay_us;
    logic [3:0]  column;
    logic [16:0] silence_us;

    out_beat_t   owed_results [$];
    int          n_fail;
    int          n_checked;
    int          n_accepted;
    int          n_timeout;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            n_fail++;
            if (n_fail <= PRINT_CAP)
                $display("mismatch on %s: got %0h, want %0h (t=%0t)", what, got, want, $time);
        end
    endtask

    task automatic predict_hop(input in_beat_t ev, output out_beat_t res);
        logic [17:0] sum;
        logic [16:0] rem;
        logic [3:0]  nskip;
        logic [3:0]  step;
        logic [3:0]  off;
        logic        well_formed;
        status_t     st;
        int          k;
        begin
            step = bound_id[0] ? 4'd15 : 4'd1;
            sum = {1'b0, silence_us} + {2'b0, ev.elapsed_us};
            silence_us = (sum > {1'b0, SILENCE_SAT}) ? SILENCE_SAT : sum[16:0];
            nskip = 4'd0;
            st = ST_IDLE;
            case (ev.cmd)
                CMD_POLL:
                begin
                    if (silence_us > {1'b0, silence_limit})
                    begin
                        column = column + step;
                        silence_us = '0;
                        st = ST_TIMEOUT;
                    end
                end
                CMD_ERROR:
                begin
                    st = ST_CRC;
                end
                CMD_PACKET:
                begin
                    well_formed = (ev.header_byte == SYNC_HEADER);
                    for (k = 0; k < 6; k++)
                    begin
                        if (ev.msb_bytes[8*k+4 +: 4] != 4'd0)
                            well_formed = 1'b0;
                    end
                    if (!well_formed)
                        st = ST_FORMAT;
                    else if (ev.packet_id != bound_id)
                        st = ST_MISMATCH;
                    else
                    begin
                        rem = {1'b0, ev.loop_time_us} + {1'b0, proc_delay_us};
                        for (k = 0; k < SKIP_CAP && rem >= {1'b0, dwell_us}; k++)
                        begin
                            rem = rem - {1'b0, dwell_us};
                            nskip = nskip + 4'd1;
                        end
                        column = column + nskip + step;
                        silence_us = '0;
                        st = ST_ACCEPT;
                    end
                end
                default:
                begin
                    column = step;
                    silence_us = '0;
                    st = ST_IDLE;
                end
            endcase
            off = (bound_id[7:4] > OFFSET_MAX) ? OFFSET_MAX : bound_id[7:4];
            res.radio_channel = CHAN_TABLE[bound_id[3:1]][column] - {4'd0, off} - 8'd1;
            res.status = st;
            res.skipped = nskip;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t res;
        out_beat_t want;
        if (!rst_n)
        begin
            bound_id = TX_ID_RESET;
            silence_limit = IDLE_TIMEOUT_RESET;
            dwell_us = HOP_PERIOD_RESET;
            proc_delay_us = READ_DELAY_RESET;
            column = '0;
            silence_us = '0;
            owed_results.delete();
            n_fail = 0;
            n_checked = 0;
            n_accepted = 0;
            n_timeout = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_addr_t'(paddr[3:2]))
                    REG_TX_ID:        bound_id = pwdata;
                    REG_IDLE_TIMEOUT: silence_limit = pwdata[15:0];
                    REG_HOP_PERIOD:   dwell_us = pwdata[15:0];
                    REG_READ_DELAY:   proc_delay_us = pwdata[15:0];
                    default:          ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("unexpected result beat", 64'(out_data), 64'd0);
                else
                begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (want.status == ST_ACCEPT)
                        n_accepted++;
                    if (want.status == ST_TIMEOUT)
                        n_timeout++;
                    if (out_data.radio_channel !== want.radio_channel)
                        report_mismatch("radio_channel", 64'(out_data.radio_channel),
                                        64'(want.radio_channel));
                    if (out_data.status !== want.status)
                        report_mismatch("status", 64'(out_data.status), 64'(want.status));
                    if (out_data.skipped !== want.skipped)
                        report_mismatch("skipped", 64'(out_data.skipped), 64'(want.skipped));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_hop(in_data, res);
                owed_results.push_back(res);
            end
        end
        fail_count <= n_fail;
        pending <= owed_results.size();
        checked <= n_checked;
        accepted_pkts <= n_accepted;
        timeout_hops <= n_timeout;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import rchc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_EVENTS   = 115;
    localparam int DRAIN_CYCLES   = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_beat_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_beat_t          out_data;

    int fail_count;
    int results_owed;
    int checked;
    int accepted_pkts;
    int timeout_hops;

    logic [31:0] cur_id      = TX_ID_RESET;
    logic [15:0] cur_timeout = IDLE_TIMEOUT_RESET;
    logic [15:0] cur_period  = HOP_PERIOD_RESET;
    int          n_cmd [4]   = '{0, 0, 0, 0};
    int          n_settings  = 1;
    int          quiet_cycles = 0;

    int          stall_mode = 0;
    int          mode_left  = 0;
    int          hold_left  = 0;

    always #4 clk = ~clk;

    rc_receiver_hop_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    hop_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending       (results_owed),
        .checked       (checked),
        .accepted_pkts (accepted_pkts),
        .timeout_hops  (timeout_hops)
    );

    // receiver back-pressure: free running, random, or long alternating stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    out_stall <= !out_stall;
                    hold_left <= out_stall ? $urandom_range(0, 6) : $urandom_range(1, 20);
                end
                else
                    hold_left <= hold_left - 1;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic in_beat_t pack_event(input cmd_t c, input logic [15:0] elapsed,
                                            input logic [7:0] hdr, input logic [31:0] id,
                                            input logic [47:0] msb, input logic [15:0] loop_us);
        in_beat_t ev;
        begin
            ev.cmd = c;
            ev.elapsed_us = elapsed;
            ev.header_byte = hdr;
            ev.packet_id = id;
            ev.msb_bytes = msb;
            ev.loop_time_us = loop_us;
            return ev;
        end
    endfunction

    task automatic send_event(input in_beat_t ev);
        begin
            in_valid <= 1'b1;
            in_data <= ev;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            n_cmd[ev.cmd]++;
        end
    endtask

    task automatic wait_for_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (results_owed != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input reg_addr_t r, input logic [31:0] v);
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {r, 2'b00};
            pwdata <= v;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    task automatic apply_settings(input logic [31:0] id, input logic [15:0] timeout,
                                  input logic [15:0] period, input logic [15:0] delay);
        begin
            write_reg(REG_TX_ID, id);
            write_reg(REG_IDLE_TIMEOUT, {16'd0, timeout});
            write_reg(REG_HOP_PERIOD, {16'd0, period});
            write_reg(REG_READ_DELAY, {16'd0, delay});
            cur_id = id;
            cur_timeout = timeout;
            cur_period = period;
            n_settings++;
        end
    endtask

    initial
    begin
        in_beat_t    ev;
        int          phase;
        int          i;
        int          pick;
        int          span;
        int          burst_left;
        logic        no_gaps;
        logic [31:0] id_v;
        logic [15:0] tmo_v;
        logic [15:0] per_v;
        logic [15:0] dly_v;
        logic [47:0] noise;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: timeout hops, saturation, every reject, skip-ahead, restart
        send_event(pack_event(CMD_POLL, 16'd0, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_POLL, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, '1, 16'hFFFF));
        send_event(pack_event(CMD_ERROR, 16'hFFFF, 8'h55, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_ERROR, 16'hFFFF, 8'h55, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_ERROR, 16'hFFFF, 8'h55, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_POLL, 16'd0, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h54, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'hFF, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'h0, 48'h0000_0000_00F0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'h0, 48'hF000_0000_0000, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'hFFFFFFFF, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'h0, 48'h0, 16'hFFFF));
        send_event(pack_event(CMD_PACKET, 16'd10, 8'h55, 32'h0, 48'h0F0F_0F0F_0F0F, 16'd300));
        send_event(pack_event(CMD_RESTART, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, '1, 16'hFFFF));
        wait_for_results();

        // backward hopping, zero timeout, zero hop period
        apply_settings(32'hFFFFFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_event(pack_event(CMD_POLL, 16'd0, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_POLL, 16'd1, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_RESTART, 16'd0, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_PACKET, 16'd5, 8'h55, 32'hFFFFFFFF, 48'h0, 16'hFFFF));
        send_event(pack_event(CMD_PACKET, 16'd5, 8'h55, 32'hFFFFFFFF, 48'h0, 16'd0));
        wait_for_results();

        apply_settings(32'h0000_00A4, 16'hFFFF, 16'hFFFF, 16'd0);
        send_event(pack_event(CMD_PACKET, 16'd0, 8'h55, 32'h0000_00A4, 48'h0, 16'hFFFF));
        send_event(pack_event(CMD_PACKET, 16'd0, 8'h55, 32'h0000_00A4, 48'h0, 16'hFFFE));
        send_event(pack_event(CMD_POLL, 16'hFFFF, 8'h00, 32'h0, 48'h0, 16'd0));
        send_event(pack_event(CMD_POLL, 16'd1, 8'h00, 32'h0, 48'h0, 16'd0));
        wait_for_results();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       id_v = 32'h0;
                1:       id_v = 32'hFFFFFFFF;
                default: id_v = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       tmo_v = 16'd0;
                1:       tmo_v = 16'hFFFF;
                2:       tmo_v = 16'($urandom);
                default: tmo_v = 16'($urandom_range(0, 20000));
            endcase
            case ($urandom_range(0, 7))
                0:       per_v = 16'd0;
                1:       per_v = 16'd1;
                2:       per_v = 16'hFFFF;
                3:       per_v = 16'($urandom);
                default: per_v = 16'($urandom_range(200, 3000));
            endcase
            case ($urandom_range(0, 4))
                0:       dly_v = 16'd0;
                1:       dly_v = 16'hFFFF;
                2:       dly_v = 16'($urandom);
                default: dly_v = 16'($urandom_range(0, 5000));
            endcase
            apply_settings(id_v, tmo_v, per_v, dly_v);
            no_gaps = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 20);

            for (i = 0; i < PHASE_EVENTS; i++)
            begin
                noise = 48'({$urandom, $urandom});
                ev.elapsed_us = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                              : 16'($urandom_range(0, int'(cur_timeout) / 4 + 100));
                span = int'(cur_period) * 11;
                if (span > 65535)
                    span = 65535;
                ev.loop_time_us = $urandom_range(0, 1) ? 16'($urandom)
                                : 16'($urandom_range(0, span));
                ev.header_byte = 8'($urandom);
                ev.packet_id = $urandom;
                ev.msb_bytes = noise;
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    ev.cmd = CMD_POLL;
                else if (pick < 40)
                    ev.cmd = CMD_ERROR;
                else if (pick < 85)
                begin
                    ev.cmd = CMD_PACKET;
                    ev.header_byte = DATA_HEADER;
                    ev.packet_id = cur_id;
                    ev.msb_bytes = noise & 48'h0F0F_0F0F_0F0F;
                    case ($urandom_range(0, 9))
                        0: ev.header_byte = 8'($urandom);
                        1: ev.msb_bytes = noise;
                        2: ev.packet_id = $urandom;
                        3: ev.packet_id = cur_id ^ (32'd1 << $urandom_range(0, 31));
                        default: ;
                    endcase
                end
                else
                    ev.cmd = CMD_RESTART;
                send_event(ev);

                if (!no_gaps)
                begin
                    if (burst_left == 0)
                    begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge clk);
                        burst_left = $urandom_range(1, 20);
                    end
                    else
                        burst_left--;
                    if ($urandom_range(0, 59) == 0)
                        wait_for_results();
                end
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d events: %0d polls, %0d errors, %0d packets, %0d restarts, %0d settings",
                 n_cmd[0] + n_cmd[1] + n_cmd[2] + n_cmd[3],
                 n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3], n_settings);
        $display("%0d result beats checked, %0d packets accepted, %0d timeout hops",
                 checked, accepted_pkts, timeout_hops);
        if (fail_count == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
